### rtl/xbr_pkg.sv
package xbr_pkg;

    localparam logic [63:0] SM_GAMMA        = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SM_MUL1         = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SM_MUL2         = 64'h94d049bb133111eb;
    localparam logic [63:0] ZERO_SEED_SUBST = 64'h6a09e667f3bcc909;
    localparam logic [63:0] RESET_SEED      = 64'd1;

    localparam int unsigned BOUND_W = 31;
    localparam int unsigned DIV_STEPS = 64;

    localparam logic MODE_RAW     = 1'b0;
    localparam logic MODE_UNIFORM = 1'b1;

    // xoshiro256** scrambler: rotl(s1 * 5, 7) * 9, multiplies done as shift-add
    function automatic logic [63:0] scramble(input logic [63:0] s1);
        logic [63:0] x5;
        logic [63:0] rot;
        x5  = s1 + (s1 << 2);
        rot = {x5[56:0], x5[63:57]};
        return rot + (rot << 3);
    endfunction

endpackage

### rtl/xoshiro_bounded_random_top.sv
// xoshiro256** random source with bounded uniform draws.
//
// Request channel (in_valid / in_stall) carries mode and bound; result
// channel (out_valid / out_stall) carries value, one result beat per request.
// seed_we with seed_data reseeds the generator; write only while idle.
//
// One request is handled at a time; in_stall stays high while it is worked.
// A raw request passes the draw state and then the done state; a zero bound
// goes straight to done (the generator does not advance); a uniform one runs
// the restoring divider for the rejection threshold, draws (each rejection
// draws again), runs the divider for the modulo, and loads the output in done.
// The block is idle again, ready for the next request, when the result appears.
//
// At reset, and after each seed write, four splitmix64 steps fill the state
// on a shared 32x32 multiplier; in_stall is high meanwhile.
// The result is held in an output register; when the receiver stalls the
// block may take one more request and finish it, then waits until the
// output register is free.
module xoshiro_bounded_random_top
    import xbr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                seed_we,
    input  logic [63:0]         seed_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                mode,
    input  logic [BOUND_W-1:0]  bound,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [63:0]         value
);

    localparam logic [3:0] ST_EXP_ADD = 4'd0;
    localparam logic [3:0] ST_MUL1    = 4'd1;
    localparam logic [3:0] ST_MIX27   = 4'd2;
    localparam logic [3:0] ST_MUL2    = 4'd3;
    localparam logic [3:0] ST_FIN     = 4'd4;
    localparam logic [3:0] ST_IDLE    = 4'd5;
    localparam logic [3:0] ST_THR     = 4'd6;
    localparam logic [3:0] ST_DRAW    = 4'd7;
    localparam logic [3:0] ST_MOD     = 4'd8;
    localparam logic [3:0] ST_DONE    = 4'd9;

    localparam logic [5:0] CNT_LAST = 6'(DIV_STEPS - 1);

    // control state
    logic [3:0]  state_reg, state_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  word_reg, word_next;
    logic [1:0]  mstep_reg, mstep_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;

    // datapath
    logic [63:0]        z_reg, z_next;
    logic [63:0]        prod_reg, prod_next;
    logic [63:0]        s_reg [4];
    logic [63:0]        s_next [4];
    logic               mode_reg, mode_next;
    logic [BOUND_W-1:0] bound_reg, bound_next;
    logic [BOUND_W-1:0] thr_reg, thr_next;
    logic [BOUND_W-1:0] rem_reg, rem_next;
    logic [63:0]        dvd_reg, dvd_next;
    logic [63:0]        res_reg, res_next;
    logic [63:0]        value_reg, value_next;

    logic               in_accept;
    logic               out_accept;
    logic [63:0]        mul_const;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_prod;
    logic [63:0]        mul_sum;
    logic [BOUND_W:0]   div_t;
    logic [BOUND_W-1:0] div_rem;
    logic [63:0]        draw_val;
    logic [63:0]        s3_mix;

    assign in_stall   = (state_reg != ST_IDLE) || seed_we;
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign out_accept = out_valid_reg && !out_stall;
    assign value      = value_reg;

    // shared 32x32 multiplier: low 64 bits of z * c from three partial products
    assign mul_const = (state_reg == ST_MUL2) ? SM_MUL2 : SM_MUL1;
    assign mul_a     = (mstep_reg == 2'd2) ? z_reg[63:32] : z_reg[31:0];
    assign mul_b     = (mstep_reg == 2'd1) ? mul_const[63:32] : mul_const[31:0];
    assign mul_prod  = {32'd0, mul_a} * {32'd0, mul_b};
    assign mul_sum   = (mstep_reg == 2'd0) ? mul_prod
                                           : prod_reg + {mul_prod[31:0], 32'd0};

    // shared restoring divider step, remainder stays below bound
    assign div_t   = {rem_reg, dvd_reg[63]};
    assign div_rem = (div_t >= {1'b0, bound_reg})
                   ? BOUND_W'(div_t - {1'b0, bound_reg})
                   : div_t[BOUND_W-1:0];

    assign draw_val = scramble(s_reg[1]);
    assign s3_mix   = s_reg[3] ^ s_reg[1];

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        word_next      = word_reg;
        mstep_next     = mstep_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        z_next         = z_reg;
        prod_next      = prod_reg;
        for (int i = 0; i < 4; i++)
        begin
            s_next[i] = s_reg[i];
        end
        mode_next  = mode_reg;
        bound_next = bound_reg;
        thr_next   = thr_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        res_next   = res_reg;
        value_next = value_reg;

        if (out_accept)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_EXP_ADD:
            begin
                acc_next   = acc_reg + SM_GAMMA;
                z_next     = acc_next ^ (acc_next >> 30);
                mstep_next = 2'd0;
                state_next = ST_MUL1;
            end
            ST_MUL1, ST_MUL2:
            begin
                prod_next = mul_sum;
                if (mstep_reg == 2'd2)
                begin
                    mstep_next = 2'd0;
                    state_next = (state_reg == ST_MUL1) ? ST_MIX27 : ST_FIN;
                end
                else
                begin
                    mstep_next = mstep_reg + 2'd1;
                end
            end
            ST_MIX27:
            begin
                z_next     = prod_reg ^ (prod_reg >> 27);
                state_next = ST_MUL2;
            end
            ST_FIN:
            begin
                s_next[word_reg] = prod_reg ^ (prod_reg >> 31);
                word_next        = word_reg + 2'd1;
                state_next       = (word_reg == 2'd3) ? ST_IDLE : ST_EXP_ADD;
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    mode_next  = mode;
                    bound_next = bound;
                    if (mode == MODE_RAW)
                    begin
                        state_next = ST_DRAW;
                    end
                    else if (bound == '0)
                    begin
                        res_next   = 64'd0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // (2^64 - bound) mod bound
                        dvd_next   = 64'd0 - {33'd0, bound};
                        rem_next   = '0;
                        cnt_next   = 6'd0;
                        state_next = ST_THR;
                    end
                end
            end
            ST_THR:
            begin
                rem_next = div_rem;
                dvd_next = {dvd_reg[62:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == CNT_LAST)
                begin
                    thr_next   = div_rem;
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                s_next[2] = s_reg[2] ^ s_reg[0] ^ (s_reg[1] << 17);
                s_next[3] = {s3_mix[18:0], s3_mix[63:19]};
                s_next[1] = s_reg[1] ^ s_reg[2] ^ s_reg[0];
                s_next[0] = s_reg[0] ^ s3_mix;
                if (mode_reg == MODE_RAW)
                begin
                    res_next   = draw_val;
                    state_next = ST_DONE;
                end
                else if (draw_val >= {33'd0, thr_reg})
                begin
                    dvd_next   = draw_val;
                    rem_next   = '0;
                    cnt_next   = 6'd0;
                    state_next = ST_MOD;
                end
                // rejected draw: stay and draw again
            end
            ST_MOD:
            begin
                rem_next = div_rem;
                dvd_next = {dvd_reg[62:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == CNT_LAST)
                begin
                    res_next   = {33'd0, div_rem};
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    value_next     = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // reseed restarts the splitmix64 expansion
        if (seed_we)
        begin
            acc_next   = (seed_data == 64'd0) ? ZERO_SEED_SUBST : seed_data;
            word_next  = 2'd0;
            mstep_next = 2'd0;
            state_next = ST_EXP_ADD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_EXP_ADD;
            acc_reg       <= RESET_SEED;
            word_reg      <= 2'd0;
            mstep_reg     <= 2'd0;
            cnt_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            word_reg      <= word_next;
            mstep_reg     <= mstep_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg     <= z_next;
        prod_reg  <= prod_next;
        for (int i = 0; i < 4; i++)
        begin
            s_reg[i] <= s_next[i];
        end
        mode_reg  <= mode_next;
        bound_reg <= bound_next;
        thr_reg   <= thr_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        res_reg   <= res_next;
        value_reg <= value_next;
    end

    a_mod_rem_below_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD || state_reg == ST_THR) |-> (rem_reg < bound_reg))
        else $error("divider remainder not below bound");

    a_uniform_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && mode_reg == MODE_UNIFORM && bound_reg != '0)
        |-> (res_reg < {33'd0, bound_reg}))
        else $error("uniform result out of range");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result beat raised outside done state");

    a_mul_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL1 || state_reg == ST_MUL2) |-> (mstep_reg != 2'd3))
        else $error("multiplier step out of range");

    a_idle_word_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (word_reg == 2'd0))
        else $error("expansion word counter not wrapped at idle");

endmodule

### dv/xoshiro_result_checker.sv
module xoshiro_result_checker
    import xbr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                seed_we,
    input  logic [63:0]         seed_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                mode,
    input  logic [BOUND_W-1:0]  bound,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [63:0]         value,
    output int unsigned         fail_count,
    output int unsigned         pending
);

    logic [63:0] gen_state [4];
    logic [63:0] expected_values [$];

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned k);
        return (x << k) | (x >> (64 - k));
    endfunction

    // splitmix64 fill of the four state words
    function automatic void load_seed(input logic [63:0] sd);
        logic [63:0] acc;
        logic [63:0] z;
        acc = (sd == 64'd0) ? ZERO_SEED_SUBST : sd;
        for (int i = 0; i < 4; i++)
        begin
            acc = acc + SM_GAMMA;
            z = acc;
            z = (z ^ (z >> 30)) * SM_MUL1;
            z = (z ^ (z >> 27)) * SM_MUL2;
            gen_state[i] = z ^ (z >> 31);
        end
    endfunction

    function automatic logic [63:0] next_raw();
        logic [63:0] res;
        logic [63:0] t;
        res = rotl64(gen_state[1] * 64'd5, 7) * 64'd9;
        t = gen_state[1] << 17;
        gen_state[2] = gen_state[2] ^ gen_state[0];
        gen_state[3] = gen_state[3] ^ gen_state[1];
        gen_state[1] = gen_state[1] ^ gen_state[2];
        gen_state[0] = gen_state[0] ^ gen_state[3];
        gen_state[2] = gen_state[2] ^ t;
        gen_state[3] = rotl64(gen_state[3], 45);
        return res;
    endfunction

    function automatic logic [63:0] predict_value(input logic m, input logic [BOUND_W-1:0] b);
        logic [63:0] lim;
        logic [63:0] thr;
        logic [63:0] r;
        lim = {{(64 - BOUND_W){1'b0}}, b};
        if (m == MODE_RAW)
            return next_raw();
        // zero bound answers 0 without touching the generator
        if (lim == 64'd0)
            return 64'd0;
        thr = (64'd0 - lim) % lim;
        do
        begin
            r = next_raw();
        end
        while (r < thr);
        return r % lim;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0] want;
        if (!rst_n)
        begin
            load_seed(RESET_SEED);
            expected_values.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_values.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual %h", $time, value);
                    fail_count++;
                end
                else
                begin
                    want = expected_values.pop_front();
                    if (value !== want)
                    begin
                        $display("%0t: value mismatch, expected %h, actual %h",
                                 $time, want, value);
                        fail_count++;
                    end
                end
            end
            if (seed_we)
                load_seed(seed_data);
            if (in_valid && !in_stall)
                expected_values.insert(expected_values.size(), predict_value(mode, bound));
            pending = expected_values.size();
        end
    end

endmodule

### dv/tb_xoshiro_bounded_random_top.sv
module tb_xoshiro_bounded_random_top;
    import xbr_pkg::*;

    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned PHASE_ITEMS = 305;

    logic               clk;
    logic               rst_n;
    logic               seed_we;
    logic [63:0]        seed_data;
    logic               in_valid;
    logic               in_stall;
    logic               mode;
    logic [BOUND_W-1:0] bound;
    logic               out_valid;
    logic               out_stall;
    logic [63:0]        value;

    int unsigned        fail_count;
    int unsigned        pending;
    bit                 hold_off_req;

    xoshiro_bounded_random_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed_we   (seed_we),
        .seed_data (seed_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .bound     (bound),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value)
    );

    xoshiro_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_we    (seed_we),
        .seed_data  (seed_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .bound      (bound),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [BOUND_W-1:0] pick_bound();
        logic [BOUND_W-1:0] b;
        case ($urandom_range(0, 9))
            0: b = '0;
            1: b = BOUND_W'($urandom_range(1, 16));
            2: b = BOUND_W'(1) << $urandom_range(0, BOUND_W - 1);
            3: b = {BOUND_W{1'b1}} - BOUND_W'($urandom_range(0, 15));
            default: b = BOUND_W'($urandom());
        endcase
        return b;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_req(input logic m, input logic [BOUND_W-1:0] b);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        bound <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_seed(input logic [63:0] sd);
        drain();
        seed_data <= sd;
        seed_we <= 1'b1;
        @(negedge clk);
        seed_we <= 1'b0;
        @(negedge clk);
    endtask

    // result side: random stalls, and one long hold-off on request
    initial
    begin
        int unsigned r;
        out_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                r = $urandom_range(0, 99);
                repeat ((r < 85) ? $urandom_range(1, 12) : $urandom_range(50, 200))
                    @(negedge clk);
                out_stall <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 70)
                    repeat ($urandom_range(1, 3)) @(negedge clk);
                else if (r < 95)
                    repeat ($urandom_range(4, 10)) @(negedge clk);
                else
                    repeat ($urandom_range(30, 100)) @(negedge clk);
            end
        end
    end

    // no beat on any channel for too long means the block is stuck
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || seed_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("** xoshiro_bounded_random_top: FAILED **");
        $finish;
    end

    initial
    begin
        logic [63:0] seed_pick;
        rst_n = 1'b0;
        seed_we = 1'b0;
        seed_data = '0;
        in_valid = 1'b0;
        mode = MODE_RAW;
        bound = '0;
        hold_off_req = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset seed: raw draws, zero bound, tiny and extreme bounds
        send_req(MODE_RAW, '0);
        send_req(MODE_RAW, {BOUND_W{1'b1}});
        send_req(MODE_UNIFORM, '0);
        send_req(MODE_UNIFORM, BOUND_W'(1));
        send_req(MODE_UNIFORM, BOUND_W'(2));
        send_req(MODE_UNIFORM, BOUND_W'(3));
        send_req(MODE_UNIFORM, {BOUND_W{1'b1}});
        send_req(MODE_UNIFORM, {BOUND_W{1'b1}} - BOUND_W'(1));
        send_req(MODE_UNIFORM, BOUND_W'(1) << (BOUND_W - 1));
        send_req(MODE_UNIFORM, '0);
        send_req(MODE_RAW, '0);

        // zero seed takes the substitute constant
        write_seed(64'd0);
        send_req(MODE_RAW, '0);
        send_req(MODE_UNIFORM, BOUND_W'(10));
        send_req(MODE_UNIFORM, '0);
        send_req(MODE_RAW, '0);

        write_seed({64{1'b1}});
        send_req(MODE_RAW, '0);
        send_req(MODE_UNIFORM, {BOUND_W{1'b1}});
        send_req(MODE_UNIFORM, BOUND_W'(6));

        write_seed(RESET_SEED);
        send_req(MODE_RAW, '0);
        send_req(MODE_UNIFORM, BOUND_W'(1000));

        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 3)
                seed_pick = 64'($urandom_range(0, 3));
            else
                seed_pick = {$urandom(), $urandom()};
            write_seed(seed_pick);
            // stall results for a long stretch while requests keep coming
            if (phase == 1 || phase == 4)
                hold_off_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_req($urandom_range(0, 1) ? MODE_UNIFORM : MODE_RAW, pick_bound());
        end

        drain();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** xoshiro_bounded_random_top: PASSED **");
        else
            $display("** xoshiro_bounded_random_top: FAILED **");
        $finish;
    end

endmodule

### filelist.f
rtl/xbr_pkg.sv
rtl/xoshiro_bounded_random_top.sv
dv/xoshiro_result_checker.sv
dv/tb_xoshiro_bounded_random_top.sv
